// ===== hw/rtl/bpfm_pkg.sv =====
package bpfm_pkg;

  // field widths fixed by the request and result formats
  localparam int INDEX_W   = 6;
  localparam int INDEX_SPAN = 64;
  localparam int LEN_W     = 7;
  localparam int LEN_SPAN  = 127;
  localparam int OUT_OFS_W = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [INDEX_W-1:0] pattern_index;
    logic [7:0]         data_byte;
    logic               last;
  } item_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFS_W-1:0] match_offset;
  } result_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic               step;
    logic               clear;
    logic               load;
    logic [INDEX_W-1:0] index;
    logic [7:0]         data;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bpfm_cell.sv =====
module bpfm_cell #(
  parameter int INDEX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bpfm_pkg::cell_ctrl_t   ctrl,
  input  logic                   prev_match,
  output logic                   cur_match,
  output logic                   match
);
  import bpfm_pkg::*;

  logic [7:0] pattern;
  logic       loadable;

  // cells past the reach of the 6-bit index are never written
  generate
    if (INDEX < INDEX_SPAN) begin : g_idx
      assign loadable = ctrl.load && (ctrl.index == INDEX_W'(INDEX));
    end else begin : g_noidx
      assign loadable = 1'b0;
    end
  endgenerate

  assign cur_match = prev_match && (ctrl.data == pattern);

  always_ff @(posedge clk) begin
    if (loadable) begin
      pattern <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.step) begin
      match <= cur_match;
    end
  end

endmodule

// ===== hw/rtl/bpfm_out_buf.sv =====
module bpfm_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bpfm_pkg::result_t   push_data,
  output logic                full,
  output logic                result_valid,
  input  logic                result_stall,
  output bpfm_pkg::result_t   result
);
  import bpfm_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        result       <= skid;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
        result       <= push_data;
      end
    end else if (!result_valid) begin
      result_valid <= push;
      result       <= push_data;
    end else if (push) begin
      skid_valid   <= 1'b1;
      skid         <= push_data;
    end
  end

endmodule

// ===== hw/rtl/byte_pattern_first_match_unit.sv =====
// a result request is registered in the output buffer before it is offered
// throughput: one request per cycle unless stalled, loads and search bytes alike; the
//   byte compare runs in parallel in MAX_PATTERN chained cells, one pattern byte each
// a two-entry output buffer keeps the input open while one result waits
// reset (rst, synchronous): clears partial matches, position, hit flag, output buffer,
//   and sets pattern_length to 1; pattern bytes are undefined until loaded
module byte_pattern_first_match_unit #(
  parameter int MAX_PATTERN  = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  bpfm_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bpfm_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [bpfm_pkg::LEN_W-1:0]        cfg_wdata
);
  import bpfm_pkg::*;

  // longest length the 7-bit register can select
  localparam int MAX_LEN = (MAX_PATTERN < LEN_SPAN) ? MAX_PATTERN : LEN_SPAN;

  // configuration
  logic [LEN_W-1:0] pattern_length;

  // search state
  logic [OFFSET_WIDTH-1:0] byte_position;
  logic                    hit_seen;

  // request decode
  logic       accept;
  logic       search;
  logic       step;
  logic       clear;
  logic       hit;
  logic       push;
  result_t    push_data;
  cell_ctrl_t ctrl;
  logic       buf_full;

  // length handling: zero acts as one, large values clamp to the chain length
  logic [LEN_W-1:0]        eff_len_m1;
  logic [OFFSET_WIDTH-1:0] start;

  // chain wiring
  logic [MAX_PATTERN-1:0] cur_vec;
  logic [MAX_PATTERN-1:0] match_vec;
  logic [MAX_PATTERN-1:0] end_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
    end else if (cfg_we) begin
      pattern_length <= cfg_wdata;
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      eff_len_m1 = '0;
    end else if (pattern_length > LEN_W'(MAX_LEN)) begin
      eff_len_m1 = LEN_W'(MAX_LEN - 1);
    end else begin
      eff_len_m1 = pattern_length - LEN_W'(1);
    end
  end

  // input is held only while the skid entry is occupied
  assign item_stall = buf_full;
  assign accept     = item_valid && !item_stall;
  assign search     = accept && (item.command == CMD_SEARCH);
  assign step       = search && !hit_seen;
  assign clear      = search && item.last;

  assign ctrl.step  = step;
  assign ctrl.clear = clear;
  assign ctrl.load  = accept && (item.command == CMD_LOAD);
  assign ctrl.index = item.pattern_index;
  assign ctrl.data  = item.data_byte;

  // row of cells: each compares the byte against its pattern byte and
  // passes its partial-match bit to the next cell
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic prev;
      if (gi == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = match_vec[gi-1];
      end

      bpfm_cell #(
        .INDEX (gi)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .prev_match (prev),
        .cur_match  (cur_vec[gi]),
        .match      (match_vec[gi])
      );

      // tap of the cell that closes the pattern
      if (gi < MAX_LEN) begin : g_tap
        assign end_sel[gi] = (eff_len_m1 == LEN_W'(gi));
      end else begin : g_notap
        assign end_sel[gi] = 1'b0;
      end
    end
  endgenerate

  assign hit = step && (|(cur_vec & end_sel));

  // start offset, floored at zero while the position is short of the length
  always_comb begin
    if (byte_position >= OFFSET_WIDTH'(eff_len_m1)) begin
      start = byte_position - OFFSET_WIDTH'(eff_len_m1);
    end else begin
      start = '0;
    end
  end

  // found on the first hit, not-found on a last byte with no hit
  assign push                   = hit || (clear && !hit_seen);
  assign push_data.found        = hit;
  assign push_data.match_offset = hit ? OUT_OFS_W'(start) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      hit_seen      <= 1'b0;
    end else if (clear) begin
      byte_position <= '0;
      hit_seen      <= 1'b0;
    end else if (step) begin
      if (byte_position != '1) begin
        byte_position <= byte_position + 1'b1;
      end
      if (hit) begin
        hit_seen <= 1'b1;
      end
    end
  end

  bpfm_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a new result request only follows a push
  a_rise_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(push))
    else $error("result request without a push");

  // a hit always lies at or past the first byte, so the position has moved
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> (byte_position != '0))
    else $error("hit flag set with position zero");

  // a hit not on a last byte sets the hit flag
  a_hit_flag: assert property (@(posedge clk) disable iff (rst)
    (hit && !clear) |=> hit_seen)
    else $error("hit flag missing after a hit");

  // a push comes only from an accepted request
  a_push_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> !item_stall)
    else $error("push while input is stalled");

endmodule

// ===== tb/tb_byte_pattern_first_match_unit.sv =====
`timescale 1ns / 100ps

module tb_byte_pattern_first_match_unit;
  import bpfm_pkg::*;

  // cycles with no accepted request or result before the run is called hung
  localparam int IDLE_LIMIT   = 2000;
  // quiet cycles after the last report before idle-only actions
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 520;

  typedef enum bit {
    ROW_REQUEST,
    ROW_LENGTH
  } row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t        kind;
    item_t            req;
    logic [LEN_W-1:0] length;
    logic             typed;   // expectation written into the row
    logic             report;  // typed rows: a result is due
    result_t          want;
  } row_t;

  logic             clk;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  item_t            item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_we       = 1'b0;
  logic [LEN_W-1:0] cfg_wdata    = '0;

  // search model state
  logic [7:0]            pat_mem [INDEX_SPAN];
  logic [INDEX_SPAN-1:0] partial_hits;
  logic [OUT_OFS_W-1:0]  byte_pos;
  bit                    hit_seen;
  logic [LEN_W-1:0]      len_reg;

  result_t reports_due [$];
  int      fail_count;
  int      items_sent;

  // random shaping
  bit         quiet;     // no gaps and no stalls on either side
  bit         narrow;    // bytes drawn from a four-symbol alphabet
  logic [7:0] sym_base;

  byte_pattern_first_match_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic item_t make_req(cmd_t c, int idx, logic [7:0] d, logic l);
    item_t r;
    r.command       = c;
    r.pattern_index = INDEX_W'(idx);
    r.data_byte     = d;
    r.last          = l;
    return r;
  endfunction

  function automatic row_t req_row(cmd_t c, int idx, logic [7:0] d, logic l);
    row_t w;
    w       = '0;
    w.kind  = ROW_REQUEST;
    w.req   = make_req(c, idx, d, l);
    return w;
  endfunction

  // search byte with the result read straight off the rules
  function automatic row_t typed_row(logic [7:0] d, logic l, logic rep, logic f,
                                     logic [OUT_OFS_W-1:0] ofs);
    row_t w;
    w                   = req_row(CMD_SEARCH, 0, d, l);
    w.typed             = 1'b1;
    w.report            = rep;
    w.want.found        = f;
    w.want.match_offset = ofs;
    return w;
  endfunction

  function automatic row_t len_row(logic [LEN_W-1:0] v);
    row_t w;
    w        = '0;
    w.kind   = ROW_LENGTH;
    w.length = v;
    return w;
  endfunction

  // zero acts as one, anything past the store acts as the full store
  function automatic int eff_len(logic [LEN_W-1:0] v);
    if (v == '0)
      return 1;
    if (int'(v) > INDEX_SPAN)
      return INDEX_SPAN;
    return int'(v);
  endfunction

  function automatic logic [7:0] pick_byte();
    if (narrow)
      return sym_base ^ 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // advance the search model by one accepted request
  task automatic track_request(input item_t r, output bit got, output result_t res);
    logic [INDEX_SPAN-1:0] eq;
    int n;
    got = 1'b0;
    res = '0;
    if (r.command == CMD_LOAD) begin
      pat_mem[r.pattern_index] = r.data_byte;
    end else begin
      if (!hit_seen) begin
        n = eff_len(len_reg);
        for (int i = 0; i < INDEX_SPAN; i++)
          eq[i] = (r.data_byte == pat_mem[i]);
        // bit i: pattern bytes 0..i end on this byte
        partial_hits = {partial_hits[INDEX_SPAN-2:0], 1'b1} & eq;
        if (partial_hits[n-1]) begin
          hit_seen         = 1'b1;
          got              = 1'b1;
          res.found        = 1'b1;
          res.match_offset = (byte_pos >= OUT_OFS_W'(n - 1)) ?
                             byte_pos - OUT_OFS_W'(n - 1) : '0;
        end
        if (byte_pos != '1)
          byte_pos = byte_pos + 1'b1;
      end
      if (r.last) begin
        if (!hit_seen) begin
          got = 1'b1;
          res = '0;
        end
        partial_hits = '0;
        byte_pos     = '0;
        hit_seen     = 1'b0;
      end
    end
  endtask

  // present one request after a random gap and wait for it to be taken
  task automatic send_req(input item_t r, output bit got, output result_t res);
    int  gap;
    bit  took;
    gap = quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    do begin
      @(negedge clk);
      took = !item_stall;
      @(posedge clk);
    end while (!took);
    items_sent++;
    track_request(r, got, res);
  endtask

  task automatic issue(input item_t r);
    bit      got;
    result_t res;
    send_req(r, got, res);
    if (got)
      reports_due.push_back(res);
  endtask

  // register writes only with nothing in flight
  task automatic write_length(input logic [LEN_W-1:0] v);
    item_valid <= 1'b0;
    while (reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    len_reg = v;
    cfg_we <= 1'b0;
  endtask

  // one buffer, often carrying a whole or cut-off copy of the pattern
  task automatic run_buffer();
    logic [7:0] stream [$];
    int n, blen, at;
    n    = eff_len(len_reg);
    blen = (n > 16) ? $urandom_range(1, n + 20) : $urandom_range(1, 24);
    for (int k = 0; k < blen; k++)
      stream.push_back(pick_byte());
    if ($urandom_range(0, 2) != 0) begin
      at = $urandom_range(0, blen - 1);
      for (int j = 0; j < n && at + j < blen; j++)
        stream[at + j] = pat_mem[j];
      // near miss
      if ($urandom_range(0, 4) == 0)
        stream[$urandom_range(0, blen - 1)] ^= 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < blen; k++) begin
      if ($urandom_range(0, 24) == 0)
        issue(make_req(CMD_LOAD, $urandom_range(0, INDEX_SPAN - 1), pick_byte(),
                       1'($urandom_range(0, 1))));
      issue(make_req(CMD_SEARCH, $urandom_range(0, INDEX_SPAN - 1), stream[k],
                     logic'(k == blen - 1)));
    end
  endtask

  task automatic check_report(input result_t got);
    result_t exp;
    if (reports_due.size() == 0) begin
      $error("result with none due: found=%0b match_offset=%0d",
             got.found, got.match_offset);
      fail_count++;
    end else begin
      exp = reports_due.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0b, actual %0b", exp.found, got.found);
        fail_count++;
      end
      if (got.match_offset !== exp.match_offset) begin
        $error("match_offset: expected %0d, actual %0d",
               exp.match_offset, got.match_offset);
        fail_count++;
      end
    end
  endtask

  // result side: a random stall per result, sampled mid-cycle
  initial begin
    int      hold;
    bit      took;
    result_t seen;
    wait (rst == 1'b0);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = result_valid;
        seen = result;
        @(posedge clk);
      end while (!took);
      check_report(seen);
    end
  end

  // hang guard: counts cycles where neither side moves
  initial begin
    int idle;
    bit moved;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      moved = (item_valid && !item_stall) || (result_valid && !result_stall);
      @(posedge clk);
      idle = moved ? 0 : idle + 1;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t       plan [$];
    bit         got;
    result_t    res;
    int         goal, n;
    logic [LEN_W-1:0] new_len;

    partial_hits = '0;
    byte_pos     = '0;
    hit_seen     = 1'b0;
    len_reg      = LEN_W'(1);
    fail_count   = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    narrow       = 1'b0;
    sym_base     = '0;
    foreach (pat_mem[i])
      pat_mem[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole store so no compare ever sees an unwritten byte
    for (int i = 0; i < INDEX_SPAN; i++)
      issue(make_req(CMD_LOAD, i, 8'(i), 1'b0));

    // length still at its reset value of one, pattern byte 0 is 0x00
    plan.push_back(typed_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b1, 32'd1));
    // hit already seen: bytes ignored until the last flag
    plan.push_back(typed_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(typed_row(8'hAB, 1'b1, 1'b0, 1'b0, '0));
    // buffer ends with no match
    plan.push_back(typed_row(8'hFF, 1'b1, 1'b1, 1'b0, '0));
    // match completing on the last byte
    plan.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b1, '0));
    // load carrying the last flag only writes the store
    plan.push_back(req_row(CMD_LOAD, 0, 8'hFF, 1'b1));
    plan.push_back(typed_row(8'hFF, 1'b1, 1'b1, 1'b1, '0));
    plan.push_back(req_row(CMD_LOAD, 0, 8'h00, 1'b0));
    // zero length behaves as one
    plan.push_back(len_row(LEN_W'(0)));
    plan.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b1, '0));
    // oversized length clips to the store depth
    plan.push_back(len_row(LEN_W'(127)));
    plan.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b0, '0));
    plan.push_back(req_row(CMD_LOAD, INDEX_SPAN - 1, 8'hFF, 1'b0));
    plan.push_back(len_row(LEN_W'(2)));
    plan.push_back(typed_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(typed_row(8'h01, 1'b1, 1'b1, 1'b1, '0));
    // pattern rewritten in the middle of a buffer, partial match kept
    plan.push_back(req_row(CMD_SEARCH, 0, 8'h01, 1'b0));
    plan.push_back(req_row(CMD_SEARCH, 0, 8'h00, 1'b0));
    plan.push_back(req_row(CMD_LOAD, 1, 8'h77, 1'b0));
    plan.push_back(req_row(CMD_SEARCH, 0, 8'h77, 1'b1));
    plan.push_back(len_row(LEN_W'(INDEX_SPAN)));
    plan.push_back(req_row(CMD_SEARCH, INDEX_SPAN - 1, 8'h00, 1'b1));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_LENGTH) begin
        write_length(plan[k].length);
      end else begin
        send_req(plan[k].req, got, res);
        if (plan[k].typed) begin
          got = plan[k].report;
          res = plan[k].want;
        end
        if (got)
          reports_due.push_back(res);
      end
    end

    // random phases: new length, partly new pattern, a few buffers
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       new_len = LEN_W'(INDEX_SPAN);
        1:       new_len = LEN_W'($urandom_range(INDEX_SPAN + 1, LEN_SPAN));
        2:       new_len = '0;
        3:       new_len = LEN_W'($urandom_range(9, 40));
        default: new_len = LEN_W'($urandom_range(1, 8));
      endcase
      write_length(new_len);
      narrow   = ($urandom_range(0, 2) != 0);
      sym_base = 8'($urandom_range(0, 255));
      n        = eff_len(len_reg);
      for (int i = 0; i < n; i++)
        if ($urandom_range(0, 2) != 0)
          issue(make_req(CMD_LOAD, i, pick_byte(), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(1, 4)) run_buffer();
    end

    item_valid <= 1'b0;
    while (reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
